/* sv/cfy_pkg.sv */
// Shared types and constants for the camera frame YUV 4:2:2 to RGB decoder.
// No dependencies; compiled first.
package cfy_pkg;

    localparam int unsigned MAX_RESULTS = 4;

    // BT.601 coefficients, 16-bit fraction
    localparam logic signed [31:0] K_CR   = 32'sd104635;
    localparam logic signed [31:0] K_CG_U = -32'sd25690;
    localparam logic signed [31:0] K_CG_V = -32'sd53294;
    localparam logic signed [31:0] K_CB   = 32'sd132278;
    localparam logic signed [31:0] K_LUMA = 32'sd76310;
    localparam logic signed [31:0] CLIP_HI = 32'sh00ffffff;
    localparam logic signed [31:0] CLIP_LO = 32'sh0000ffff;

    localparam logic [9:0] SAT10 = 10'd1023;

    typedef enum logic [2:0] {
        CFG_ROI_LEFT    = 3'd0,
        CFG_ROI_RIGHT   = 3'd1,
        CFG_ROI_TOP     = 3'd2,
        CFG_ROI_BOTTOM  = 3'd3,
        CFG_ROW_STEP    = 3'd4,
        CFG_COMPRESSED  = 3'd5,
        CFG_FRAME_BYTES = 3'd6,
        CFG_LINE_PITCH  = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_HEADER   = 3'd1,
        ERR_LINE_LONG   = 3'd2,
        ERR_LEN_MISMATCH = 3'd3,
        ERR_COL_MISMATCH = 3'd4,
        ERR_LEN_MISUSE  = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        PH_HDR_LO = 2'd0,
        PH_HDR_HI = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [9:0]  roi_left;
        logic [9:0]  roi_right;
        logic [9:0]  roi_top;
        logic [9:0]  roi_bottom;
        logic [1:0]  row_step;
        logic        compressed_mode;
        logic [19:0] frame_bytes;
        logic [12:0] line_pitch_words;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [21:0] pixel_address;
        logic [23:0] pixel_color;
        logic [2:0]  error_code;
    } res_t;

    typedef struct packed {
        logic [2:0] count;
        res_t [MAX_RESULTS-1:0] items;
    } res_list_t;

endpackage

/* sv/cfy_ifs.sv */
// Channel interfaces: byte stream in, results out, configuration writes.
// No dependencies.
interface cfy_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;
    modport source (output valid, data_byte, frame_start, input ready);
    modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface cfy_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [21:0] pixel_address;
    logic [23:0] pixel_color;
    logic [2:0]  error_code;
    logic        last;
    modport source (output valid, kind, pixel_address, pixel_color, error_code, last,
                    input ready);
    modport sink   (input valid, kind, pixel_address, pixel_color, error_code, last,
                    output ready);
endinterface

interface cfy_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [19:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/cfy_color.sv */
// BT.601 YUV quad to two clipped RGB888 pixels, constant multipliers only.
// Depends on cfy_pkg.
module cfy_color (
    input  logic [23:0] quad_bytes,
    input  logic [7:0]  v_byte,
    output logic [23:0] color1,
    output logic [23:0] color2
);
    import cfy_pkg::*;

    function automatic logic [7:0] clip8(input logic signed [31:0] x);
        logic [7:0] r;
        if (x > CLIP_HI)
            r = 8'hff;
        else if (x <= CLIP_LO)
            r = 8'h00;
        else
            r = x[23:16];
        return r;
    endfunction

    logic signed [31:0] y1, u, y2, v;
    logic signed [31:0] cr, cg, cb, l1, l2;

    always_comb
    begin
        y1 = $signed({24'd0, quad_bytes[7:0]}) - 32'sd16;
        u  = $signed({24'd0, quad_bytes[15:8]}) - 32'sd128;
        y2 = $signed({24'd0, quad_bytes[23:16]}) - 32'sd16;
        v  = $signed({24'd0, v_byte}) - 32'sd128;
        cr = K_CR * v;
        cg = K_CG_U * u + K_CG_V * v;
        cb = K_CB * u;
        l1 = K_LUMA * y1;
        l2 = K_LUMA * y2;
        color1 = {clip8(cr + l1), clip8(cg + l1), clip8(cb + l1)};
        color2 = {clip8(cr + l2), clip8(cg + l2), clip8(cb + l2)};
    end

endmodule

/* sv/cfy_parser.sv */
// Frame parser: header, line body and end-of-line state, result list per byte.
// Depends on cfy_pkg and cfy_color.
module cfy_parser #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              frame_start,
    input  cfy_pkg::cfg_t     cfg,
    output cfy_pkg::res_list_t results
);
    import cfy_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] line_left_reg, line_left_next;
    logic [19:0] frame_left_reg, frame_left_next;
    logic [9:0]  column_reg, column_next;
    logic [9:0]  row_reg, row_next;
    logic [23:0] held_reg, held_next;
    logic [1:0]  qcount_reg, qcount_next;
    logic        halted_reg, halted_next;

    logic [23:0] color1, color2;

    cfy_color u_color (
        .quad_bytes (held_reg),
        .v_byte     (data_byte),
        .color1     (color1),
        .color2     (color2)
    );

    function automatic logic [9:0] sat10(input logic [10:0] x);
        return (x > {1'b0, SAT10}) ? SAT10 : x[9:0];
    endfunction

    logic [22:0] row_base;
    logic [21:0] addr0, addr2;
    logic        single_en;
    res_t        single_res;
    logic [3:0]  pix_en;
    res_t [3:0]  pix_res;
    logic [15:0] len;
    logic signed [17:0] len_m1, roi_span2;
    logic        in_loop;
    logic [1:0]  step_rows;
    logic [10:0] col1;
    logic [10:0] row1;
    logic        col_ok0, col_ok1, row_ok0, row_ok1;
    logic [2:0]  cnt;

    always_comb
    begin
        row_base = 23'(row_reg * cfg.line_pitch_words);
        addr0 = 22'(row_base + 23'(column_reg));
        addr2 = addr0 + 22'(cfg.line_pitch_words);
        col1 = {1'b0, column_reg} + 11'd1;
        row1 = {1'b0, row_reg} + 11'd1;
        col_ok0 = {1'b0, column_reg} < 11'(MAX_WIDTH);
        col_ok1 = col1 < 11'(MAX_WIDTH);
        row_ok0 = {1'b0, row_reg} < 11'(MAX_HEIGHT);
        row_ok1 = row1 < 11'(MAX_HEIGHT);
        len = {data_byte, held_reg[7:0]};
        len_m1 = $signed({2'b00, len}) - 18'sd1;
        roi_span2 = ($signed({8'd0, cfg.roi_right}) - $signed({8'd0, cfg.roi_left})) <<< 1;
        step_rows = (cfg.row_step == 2'd0) ? 2'd1 : cfg.row_step;

        pix_res[0] = '{KIND_PIXEL, addr0, color1, ERR_NONE};
        pix_res[1] = '{KIND_PIXEL, addr0 + 22'd1, color2, ERR_NONE};
        pix_res[2] = '{KIND_PIXEL, addr2, color1, ERR_NONE};
        pix_res[3] = '{KIND_PIXEL, addr2 + 22'd1, color2, ERR_NONE};
        pix_en = '0;
        single_en = 1'b0;
        single_res = '{KIND_DONE, 22'd0, 24'd0, ERR_NONE};
        in_loop = 1'b0;

        phase_next = phase_reg;
        line_left_next = line_left_reg;
        frame_left_next = frame_left_reg;
        column_next = column_reg;
        row_next = row_reg;
        held_next = held_reg;
        qcount_next = qcount_reg;
        halted_next = halted_reg;

        if (frame_start)
        begin
            halted_next = 1'b0;
            row_next = cfg.roi_top;
            column_next = '0;
            frame_left_next = cfg.frame_bytes;
            line_left_next = '0;
            held_next = '0;
            qcount_next = '0;
            phase_next = PH_HDR_LO;
            if (cfg.roi_top >= cfg.roi_bottom)
            begin
                single_en = 1'b1;
                halted_next = 1'b1;
            end
        end

        // parsing state after a frame start equals the reset copies used below
        if (!halted_next)
        begin
            unique case (phase_next)
                PH_HDR_LO:
                begin
                    if (frame_left_next < 20'd2)
                    begin
                        single_en = 1'b1;
                        single_res = '{KIND_ERROR, 22'd0, 24'd0, ERR_NO_HEADER};
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        frame_left_next = frame_left_next - 20'd2;
                        held_next = {16'd0, data_byte};
                        phase_next = PH_HDR_HI;
                    end
                end
                PH_HDR_HI:
                begin
                    if ({4'd0, len} > frame_left_reg)
                    begin
                        single_en = 1'b1;
                        single_res = '{KIND_ERROR, 22'd0, 24'd0, ERR_LINE_LONG};
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        frame_left_next = frame_left_reg - {4'd0, len};
                        if (!cfg.compressed_mode && len_m1 != roi_span2)
                        begin
                            single_en = 1'b1;
                            single_res = '{KIND_ERROR, 22'd0, 24'd0, ERR_LEN_MISMATCH};
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            line_left_next = len;
                            column_next = cfg.roi_left;
                            held_next = '0;
                            qcount_next = '0;
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (qcount_reg != 2'd0)
                    begin
                        line_left_next = line_left_reg - 16'd1;
                        if (qcount_reg == 2'd3)
                        begin
                            qcount_next = '0;
                            pix_en[0] = col_ok0 && row_ok0;
                            pix_en[1] = col_ok1 && row_ok0;
                            pix_en[2] = (cfg.row_step == 2'd2) && col_ok0 && row_ok1;
                            pix_en[3] = (cfg.row_step == 2'd2) && col_ok1 && row_ok1;
                            column_next = sat10({1'b0, column_reg} + 11'd2);
                        end
                        else
                        begin
                            if (qcount_reg == 2'd1)
                                held_next[15:8] = data_byte;
                            else
                                held_next[23:16] = data_byte;
                            qcount_next = qcount_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        in_loop = (column_reg < cfg.roi_right) &&
                                  !(cfg.compressed_mode && line_left_reg == 16'd0);
                        if (!in_loop)
                        begin
                            if (cfg.compressed_mode && column_reg != cfg.roi_right)
                            begin
                                single_en = 1'b1;
                                single_res = '{KIND_ERROR, 22'd0, 24'd0, ERR_COL_MISMATCH};
                                halted_next = 1'b1;
                            end
                            else if (cfg.compressed_mode && line_left_reg != 16'd1)
                            begin
                                single_en = 1'b1;
                                single_res = '{KIND_ERROR, 22'd0, 24'd0, ERR_LEN_MISUSE};
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                line_left_next = '0;
                                row_next = sat10({1'b0, row_reg} + {9'd0, step_rows});
                                phase_next = PH_HDR_LO;
                                if (row_next >= cfg.roi_bottom)
                                begin
                                    single_en = 1'b1;
                                    halted_next = 1'b1;
                                end
                            end
                        end
                        else if (cfg.compressed_mode && data_byte[0])
                        begin
                            // skip byte
                            column_next = sat10({1'b0, column_reg} + {4'd0, data_byte[7:1]});
                            line_left_next = line_left_reg - 16'd1;
                        end
                        else if (line_left_reg < 16'd4)
                        begin
                            single_en = 1'b1;
                            single_res = '{KIND_ERROR, 22'd0, 24'd0, ERR_LEN_MISUSE};
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            held_next = {16'd0, data_byte};
                            qcount_next = 2'd1;
                            line_left_next = line_left_reg - 16'd1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HDR_LO;
                end
            endcase
        end

        results.items = '0;
        cnt = '0;
        if (single_en)
        begin
            results.items[0] = single_res;
            cnt = 3'd1;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (pix_en[i])
                begin
                    results.items[cnt[1:0]] = pix_res[i];
                    cnt = cnt + 3'd1;
                end
            end
        end
        results.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_LO;
            line_left_reg <= '0;
            frame_left_reg <= '0;
            column_reg <= '0;
            row_reg <= '0;
            held_reg <= '0;
            qcount_reg <= '0;
            halted_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            line_left_reg <= line_left_next;
            frame_left_reg <= frame_left_next;
            column_reg <= column_next;
            row_reg <= row_next;
            held_reg <= held_next;
            qcount_reg <= qcount_next;
            halted_reg <= halted_next;
        end
    end

endmodule

/* sv/camera_frame_yuv422_to_rgb_decoder_core.sv */
// Top level: configuration registers, input byte register, parser, result buffer.
// Depends on cfy_pkg, cfy_ifs, cfy_parser.
//
//  channel  | dir | handshake     | payload
//  stream   | in  | valid/ready   | data_byte, frame_start
//  result   | out | valid/ready   | kind, pixel_address, pixel_color, error_code, last
//  cfg      | in  | valid/ready   | index, data (always ready)
//
// One byte per cycle is taken while each byte yields at most one result and the result
// port is ready; a byte that yields more results holds the stream until the single result port has sent them all.
// An accepted byte passes the input register, then the result buffer, before its first result.
// Reset leaves the parser halted until a byte with frame_start.
// A stalled result port holds the buffer; the input register then holds its byte.
module camera_frame_yuv422_to_rgb_decoder_core #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic   clk,
    input  logic   rst_n,
    cfy_stream_if.sink   stream,
    cfy_result_if.source result,
    cfy_cfg_if.sink      cfg
);
    import cfy_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{10'd0, 10'd352, 10'd0, 10'd288, 2'd1, 1'b0, 20'd0, 13'd512};
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_ROI_LEFT:    cfg_reg.roi_left <= cfg.data[9:0];
                CFG_ROI_RIGHT:   cfg_reg.roi_right <= cfg.data[9:0];
                CFG_ROI_TOP:     cfg_reg.roi_top <= cfg.data[9:0];
                CFG_ROI_BOTTOM:  cfg_reg.roi_bottom <= cfg.data[9:0];
                CFG_ROW_STEP:    cfg_reg.row_step <= cfg.data[1:0];
                CFG_COMPRESSED:  cfg_reg.compressed_mode <= cfg.data[0];
                CFG_FRAME_BYTES: cfg_reg.frame_bytes <= cfg.data;
                CFG_LINE_PITCH:  cfg_reg.line_pitch_words <= cfg.data[12:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       fs_reg;

    // result buffer
    res_t [MAX_RESULTS-1:0] buf_reg;
    logic [2:0] count_reg;
    logic [1:0] index_reg;

    logic out_fire, out_last, buf_free, step;
    res_list_t results;

    assign out_last = ({1'b0, index_reg} + 3'd1) == count_reg;
    assign out_fire = result.valid && result.ready;
    assign buf_free = (count_reg == 3'd0) || (out_fire && out_last);
    assign step = in_valid_reg && buf_free;
    assign stream.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            byte_reg <= stream.data_byte;
            fs_reg <= stream.frame_start;
        end
        if (step)
        begin
            buf_reg <= results.items;
        end
    end

    cfy_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (byte_reg),
        .frame_start (fs_reg),
        .cfg         (cfg_reg),
        .results     (results)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            index_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= results.count;
            index_reg <= '0;
        end
        else if (out_fire)
        begin
            if (out_last)
            begin
                count_reg <= '0;
                index_reg <= '0;
            end
            else
            begin
                index_reg <= index_reg + 2'd1;
            end
        end
    end

    assign result.valid = count_reg != 3'd0;
    assign result.kind = buf_reg[index_reg].kind;
    assign result.pixel_address = buf_reg[index_reg].pixel_address;
    assign result.pixel_color = buf_reg[index_reg].pixel_color;
    assign result.error_code = buf_reg[index_reg].error_code;
    assign result.last = out_last;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 3'd0 |-> {1'b0, index_reg} < count_reg)
        else $error("result index beyond buffered count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> count_reg == 3'd0 || (out_fire && out_last))
        else $error("result buffer overwritten");

    a_pixel_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_PIXEL
            |-> result.pixel_address == 22'd0 && result.pixel_color == 24'd0)
        else $error("non-pixel result carries pixel payload");

endmodule
